// ===== rtl/krma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krma_pkg
// Shared constants and the command and status types that join the
// controller of the moving average unit to its datapath.
// ----------------------------------------------------------------------------
package krma_pkg;

  // Default configuration of the block.
  localparam int MAX_RADIUS_DEF  = 31;
  localparam int SAMPLE_BITS_DEF = 32;

  // Fixed field widths.
  localparam int DATA_BITS   = 32;
  localparam int SUM_BITS    = 38;
  localparam int RADIUS_BITS = 5;

  // Configuration port.
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_RADIUS  = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd;
    logic upd;
    logic div_start;
    logic emit_main;
    logic emit_tail;
  } krma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_main;
    logic main_valid;
    logic last;
    logic div_busy;
    logic out_free;
    logic rem_zero;
    logic rem_one;
  } krma_status_t;

endpackage

// ===== rtl/krma_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krma_in_if
// Sample channel: one signed sample and its end-of-sequence flag per transfer.
// ----------------------------------------------------------------------------
interface krma_in_if import krma_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] sample;
  logic                        seq_end;

  modport source (output valid, output sample, output seq_end, input ready);
  modport sink   (input valid, input sample, input seq_end, output ready);
endinterface

// ===== rtl/krma_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krma_out_if
// Result channel: one average with its valid and final flags per transfer.
// ----------------------------------------------------------------------------
interface krma_out_if import krma_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] average;
  logic                        valid_res;
  logic                        final_res;

  modport source (output valid, output average, output valid_res, output final_res,
                  input ready);
  modport sink   (input valid, input average, input valid_res, input final_res,
                  output ready);
endinterface

// ===== rtl/k_radius_moving_average_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_radius_moving_average_unit
// Centered moving average of radius k over sequences of signed samples.
// ----------------------------------------------------------------------------
// The unit takes one sample at a time and returns, in index order, the mean of
// the 2k+1 samples centered on each index, truncated toward zero; indices
// within k of either end of the sequence come out flagged invalid with a zero
// average. A sample passes through the accept, read and update steps. One that
// releases a valid result then waits in the divide step, where the divider
// delivers one quotient bit of the 38-bit window sum per cycle, before its
// emit step; one that releases an invalid result goes straight to its emit
// step. The last sample of a sequence hands out each trailing invalid result
// in the tail step. Each result waits longer while the result register is
// still full. The result register lets the next sample enter while a result
// waits to be taken. The user must write the radius register (byte address 0)
// only while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module k_radius_moving_average_unit import krma_pkg::*; #(
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  krma_in_if.sink                  in_ch,
  krma_out_if.source               out_ch
);

  logic [RADIUS_BITS-1:0] radius;
  krma_cmd_t              cmd;
  krma_status_t           status;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RADIUS)) begin
      radius <= pwdata[RADIUS_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_RADIUS)
                ? {{(APB_DATA_BITS-RADIUS_BITS){1'b0}}, radius} : '0;

  // Sequencer.
  krma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  krma_dp #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .radius    (radius),
    .sample    (in_ch.sample),
    .seq_end   (in_ch.seq_end),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .average   (out_ch.average),
    .valid_res (out_ch.valid_res),
    .final_res (out_ch.final_res)
  );

endmodule

// ===== rtl/krma_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krma_div
// Iterative signed divider: a window sum divided by the window length,
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module krma_div import krma_pkg::*; #(
  parameter int DW = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [SUM_BITS-1:0]  dividend,
  input  logic        [DW-1:0]        divisor,
  output logic                        busy,
  output logic signed [DATA_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(SUM_BITS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic [SUM_BITS-1:0] quo;
  logic [DW-1:0]       rem;
  logic [DW-1:0]       dvs;
  logic                neg;
  logic [DW:0]         shifted;
  logic                take;
  logic [SUM_BITS-1:0] signed_quo;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, quo[SUM_BITS-1]};
    take    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_BITS'(SUM_BITS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Work on the magnitude; the sign is restored at the end.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_BITS-1];
      quo <= dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      if (take) begin
        rem <= DW'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[DW-1:0];
      end
      quo <= {quo[SUM_BITS-2:0], take};
    end
  end

  assign signed_quo = neg ? (~quo + 1'b1) : quo;
  assign quotient   = signed_quo[DATA_BITS-1:0];
  assign busy       = cnt != '0;

endmodule

// ===== rtl/krma_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krma_ctrl
// Sequencer of the moving average unit: takes one sample, reads the sample
// that leaves the window, updates the sum, divides and hands out results.
// ----------------------------------------------------------------------------
module krma_ctrl import krma_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  krma_status_t status,
  output krma_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_DIVIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_TAIL   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = state == S_IDLE;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.upd = 1'b1;
        if (status.has_main) begin
          if (status.main_valid) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIVIDE;
          end else begin
            state_next = S_EMIT;
          end
        end else if (status.last) begin
          state_next = S_TAIL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIVIDE: begin
        if (!status.div_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_main = 1'b1;
          state_next    = status.rem_zero ? S_IDLE : S_TAIL;
        end
      end
      S_TAIL: begin
        if (status.out_free) begin
          cmd.emit_tail = 1'b1;
          if (status.rem_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/krma_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krma_dp
// Datapath: circular sample store, exact window sum, sample count, divider,
// trailing-result counter and the result register.
// ----------------------------------------------------------------------------
module krma_dp import krma_pkg::*; #(
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  krma_cmd_t                   cmd,
  output krma_status_t                status,
  input  logic [RADIUS_BITS-1:0]      radius,
  input  logic signed [DATA_BITS-1:0] sample,
  input  logic                        seq_end,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [DATA_BITS-1:0] average,
  output logic                        valid_res,
  output logic                        final_res
);

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int KW    = $clog2(MAX_RADIUS + 1);
  localparam int CW    = KW + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  logic [SAMPLE_BITS-1:0] x_reg;
  logic [SAMPLE_BITS-1:0] rdata;
  logic                   last_reg;
  logic [KW-1:0]          k_reg;
  logic [CW-1:0]          w_reg;
  logic [CW-1:0]          c_reg;
  logic [CW-1:0]          count;
  logic [SUM_BITS-1:0]    sum;
  logic [AW-1:0]          wp;
  logic [KW-1:0]          rem;

  logic [KW-1:0]          k_cur;
  logic [CW-1:0]          w_cur;
  logic [AW:0]            raddr_raw;
  logic [AW-1:0]          raddr;
  logic [SUM_BITS-1:0]    x_ext;
  logic [SUM_BITS-1:0]    old_ext;
  logic [SUM_BITS-1:0]    sum_next;
  logic [CW:0]            c_inc;
  logic [KW-1:0]          rem_load;
  logic                   div_busy;
  logic signed [DATA_BITS-1:0] quotient;

  // Effective radius and window length from the register.
  always_comb begin
    k_cur = (radius > RADIUS_BITS'(MAX_RADIUS)) ? KW'(MAX_RADIUS) : radius[KW-1:0];
    w_cur = {k_cur, 1'b1};
  end

  // Latch the sample and the window geometry at the input transfer.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_reg    <= sample[SAMPLE_BITS-1:0];
      last_reg <= seq_end;
      k_reg    <= k_cur;
      w_reg    <= w_cur;
      c_reg    <= (count > w_cur) ? w_cur : count;
    end
  end

  // The leaving sample was written w transfers ago.
  always_comb begin
    raddr_raw = {1'b0, wp} + (AW+1)'(DEPTH) - (AW+1)'(w_reg);
    raddr = (raddr_raw >= (AW+1)'(DEPTH)) ? AW'(raddr_raw - (AW+1)'(DEPTH))
                                          : raddr_raw[AW-1:0];
  end

  // Sample store: read before the slot is overwritten.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[raddr];
    end
    if (cmd.upd) begin
      mem[wp] <= x_reg;
    end
  end

  // New window sum, count and trailing-result count.
  always_comb begin
    x_ext    = {{(SUM_BITS-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};
    old_ext  = {{(SUM_BITS-SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata};
    sum_next = sum - ((c_reg >= w_reg) ? old_ext : '0) + x_ext;
    c_inc    = {1'b0, c_reg} + 1'b1;
    rem_load = (c_inc < {2'b00, k_reg}) ? KW'(c_inc) : k_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      wp    <= '0;
      rem   <= '0;
    end else begin
      if (cmd.upd) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
        if (last_reg) begin
          sum   <= '0;
          count <= '0;
          rem   <= rem_load;
        end else begin
          sum   <= sum_next;
          count <= (c_inc < {1'b0, w_reg}) ? CW'(c_inc) : w_reg;
          rem   <= '0;
        end
      end else if (cmd.emit_tail) begin
        rem <= rem - 1'b1;
      end
    end
  end

  krma_div #(
    .DW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_next),
    .divisor  (w_reg),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Result register; it frees up in the cycle its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_main || cmd.emit_tail) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_main) begin
      average   <= status.main_valid ? quotient : '0;
      valid_res <= status.main_valid;
      final_res <= last_reg && (rem == '0);
    end else if (cmd.emit_tail) begin
      average   <= '0;
      valid_res <= 1'b0;
      final_res <= rem == KW'(1);
    end
  end

  // Status toward the controller.
  always_comb begin
    status.has_main   = c_reg >= {1'b0, k_reg};
    status.main_valid = c_reg >= {k_reg, 1'b0};
    status.last       = last_reg;
    status.div_busy   = div_busy;
    status.out_free   = !out_valid || out_ready;
    status.rem_zero   = rem == '0;
    status.rem_one    = rem == KW'(1);
  end

endmodule

// ===== tb/krma_avg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krma_avg_checker
// Watches the sample, result and register ports of the moving average unit,
// keeps its own window of the stream to predict every average, and compares
// each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module krma_avg_checker import krma_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  input  logic                     pready,
  krma_in_if                       in_mon,
  krma_out_if                      out_mon,
  output int                       fail_count,
  output int                       pending,
  output int                       averages_seen,
  output int                       full_windows_seen
);

  localparam int WIN_DEPTH = 2 * MAX_RADIUS_DEF + 1;
  localparam logic [APB_ADDR_BITS-1:0] RADIUS_ADDR = APB_ADDR_BITS'(4 * REG_RADIUS);

  typedef struct packed {
    logic signed [DATA_BITS-1:0] average;
    logic                        valid_res;
    logic                        final_res;
  } avg_result_t;

  // Shadow copy of the unit's window state and radius.
  logic [DATA_BITS-1:0]   hist [0:WIN_DEPTH-1];
  logic [SUM_BITS-1:0]    win_sum;
  int unsigned            fill_cnt;
  logic [RADIUS_BITS-1:0] radius_q;
  avg_result_t            avg_q [$];

  // One line per mismatch; printing stops after fifty, counting does not.
  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 50) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic void clear_window();
    for (int i = 0; i < WIN_DEPTH; i++) hist[i] = '0;
    win_sum  = '0;
    fill_cnt = 0;
  endfunction

  // Advance the shadow window by one sample and queue the averages it releases.
  function automatic void predict_averages(input logic [DATA_BITS-1:0] x, input logic last);
    int unsigned k;
    int unsigned w;
    int unsigned c;
    int unsigned tail;
    int          produced;
    longint      quot;
    avg_result_t r;
    k        = radius_q;
    w        = 2 * k + 1;
    c        = fill_cnt;
    produced = 0;
    if (c > w) c = w;

    // Drop the sample leaving a full window, then shift in the new one.
    if (c >= w) win_sum = win_sum - {{(SUM_BITS-DATA_BITS){hist[2*k][DATA_BITS-1]}}, hist[2*k]};
    for (int i = WIN_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = x;
    win_sum = win_sum + {{(SUM_BITS-DATA_BITS){x[DATA_BITS-1]}}, x};

    // The index k samples back is now centered; it is valid only with k samples before it.
    if (c >= k) begin
      quot        = longint'($signed(win_sum)) / longint'(w);
      r.valid_res = (c >= 2 * k);
      r.average   = r.valid_res ? quot[DATA_BITS-1:0] : '0;
      r.final_res = 1'b0;
      avg_q.push_back(r);
      produced++;
    end

    // At the end of a sequence the trailing indices leave as invalid results.
    if (last) begin
      tail = (c + 1 < k) ? c + 1 : k;
      r    = '{average: '0, valid_res: 1'b0, final_res: 1'b0};
      repeat (tail) begin
        avg_q.push_back(r);
        produced++;
      end
      if (produced > 0) avg_q[avg_q.size()-1].final_res = 1'b1;
      win_sum  = '0;
      fill_cnt = 0;
    end else begin
      fill_cnt = (c + 1 < w) ? c + 1 : w;
    end
  endfunction

  // Compare one result transfer against the oldest queued average.
  task automatic check_average();
    avg_result_t exp_r;
    averages_seen++;
    if (out_mon.valid_res === 1'b1) full_windows_seen++;
    if (avg_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: average %0d valid %0b final %0b",
                                out_mon.average, out_mon.valid_res, out_mon.final_res));
    end else begin
      exp_r = avg_q.pop_front();
      if (out_mon.average !== exp_r.average || out_mon.valid_res !== exp_r.valid_res ||
          out_mon.final_res !== exp_r.final_res) begin
        report_mismatch($sformatf(
          "result %0d: average %0d exp %0d, valid %0b exp %0b, final %0b exp %0b",
          averages_seen, out_mon.average, exp_r.average, out_mon.valid_res,
          exp_r.valid_res, out_mon.final_res, exp_r.final_res));
      end
    end
  endtask

  // Results are checked before the same edge's sample is predicted, so a result
  // can never be matched against a prediction made at its own edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_window();
      radius_q          = '0;
      fail_count        = 0;
      averages_seen     = 0;
      full_windows_seen = 0;
      avg_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_average();
      if (psel && penable && pwrite && pready && paddr == RADIUS_ADDR)
        radius_q = pwdata[RADIUS_BITS-1:0];
      if (in_mon.valid && in_mon.ready) predict_averages(in_mon.sample, in_mon.seq_end);
    end
    pending <= avg_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sequences of samples and radius settings into the moving average
// unit, with bursty input and a receiver that stalls in changing patterns,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
  import krma_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 260;
  localparam int SETTLE_WAIT  = 96;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [APB_ADDR_BITS-1:0] RADIUS_ADDR = APB_ADDR_BITS'(4 * REG_RADIUS);
  localparam logic [DATA_BITS-1:0] SAMPLE_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic [DATA_BITS-1:0] SAMPLE_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};
  localparam logic [DATA_BITS-1:0] SAMPLE_NEG_ONE = '1;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_LONG_STALL, RX_CADENCE} rx_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int fail_count;
  int pending;
  int averages_seen;
  int full_windows_seen;
  int cycle_count   = 0;
  int samples_sent  = 0;
  int seqs_sent     = 0;
  int radius_writes = 0;
  int burst_left    = 0;
  logic [31:0] radii_used = '0;

  rx_mode_t rx_mode       = RX_OPEN;
  int       rx_mode_left  = 0;
  int       rx_stall_left = 0;

  krma_in_if  in_ch ();
  krma_out_if out_ch ();

  k_radius_moving_average_unit uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  krma_avg_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .fail_count        (fail_count),
    .pending           (pending),
    .averages_seen     (averages_seen),
    .full_windows_seen (full_windows_seen)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit; a run that hangs ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d averages outstanding.", pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: switches between open, coin-flip, long-stall and cadence modes.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(50, 250);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        out_ch.ready <= 1'b1;
      end
      RX_COIN: begin
        out_ch.ready <= 1'($urandom_range(0, 1));
      end
      RX_LONG_STALL: begin
        if (rx_stall_left > 0) begin
          out_ch.ready  <= 1'b0;
          rx_stall_left <= rx_stall_left - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          out_ch.ready  <= 1'b0;
          rx_stall_left <= $urandom_range(4, 20);
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
      default: begin
        out_ch.ready <= (cycle_count % 3 != 0);
      end
    endcase
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_radius(input int unsigned k);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RADIUS_ADDR;
    pwdata  <= APB_DATA_BITS'(k);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    radius_writes++;
    radii_used[k] = 1'b1;
  endtask

  // Offer one sample and hold it until its transfer; bursts end in a short gap.
  task automatic send_sample(input logic [DATA_BITS-1:0] x, input logic last);
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= x;
    in_ch.seq_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
    if (last) seqs_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Wait until every predicted average has arrived and the unit has settled.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  function automatic logic [DATA_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return DATA_BITS'(int'($urandom_range(0, 200)) - 100);
      default: return DATA_BITS'($urandom());
    endcase
  endfunction

  // Main stimulus.
  initial begin
    int unsigned k;
    int unsigned seq_len;
    int unsigned seq_count;
    int          random_sent;
    int          phase;

    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.seq_end <= 1'b0;
    random_sent   = 0;
    phase         = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Radius zero out of reset: each sample is its own average.
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_NEG_ONE, 1'b1);
    wait_idle();

    // Radius one: full-scale windows and truncation toward zero.
    write_radius(1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_NEG_ONE, 1'b0);
    send_sample(SAMPLE_NEG_ONE, 1'b0);
    send_sample('0, 1'b1);
    wait_idle();

    // Sequences shorter than the window, down to a single sample.
    write_radius(2);
    send_sample(DATA_BITS'(5), 1'b1);
    send_sample(DATA_BITS'(1), 1'b0);
    send_sample(DATA_BITS'(2), 1'b0);
    send_sample(DATA_BITS'(3), 1'b1);
    wait_idle();

    // Radius raised in the middle of a sequence.
    write_radius(1);
    send_sample(DATA_BITS'(10), 1'b0);
    send_sample(DATA_BITS'(20), 1'b0);
    send_sample(DATA_BITS'(30), 1'b0);
    wait_idle();
    write_radius(3);
    send_sample(DATA_BITS'(40), 1'b0);
    send_sample(DATA_BITS'(50), 1'b0);
    send_sample(DATA_BITS'(60), 1'b1);
    wait_idle();

    // Random phases: mostly complete sequences, some no longer than the window.
    while (random_sent < RANDOM_ITEMS) begin
      if (phase == 0) k = 31;
      else if (phase == 1) k = 0;
      else if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 31);
      else k = $urandom_range(1, 4);
      write_radius(k);
      seq_count = (k > 8) ? 1 : $urandom_range(1, 3);
      repeat (seq_count) begin
        if ($urandom_range(0, 4) == 0) seq_len = $urandom_range(1, 2 * k + 1);
        else seq_len = $urandom_range(2 * k + 1, 2 * k + 9);
        for (int unsigned j = 0; j < seq_len; j++) begin
          send_sample(pick_sample(), j == seq_len - 1);
          random_sent++;
        end
      end
      wait_idle();
      phase++;
    end

    $display("Sent %0d samples in %0d sequences over %0d radius writes (%0d distinct radii).",
             samples_sent, seqs_sent, radius_writes, $countones(radii_used));
    $display("Checked %0d averages, %0d of them over full windows.",
             averages_seen, full_windows_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
